FILE: sv/fas_pkg.sv
// fas_pkg: shared types and constants for the truncating float32 add/sub block
// used by the controller, datapath and top level; no dependencies
package fas_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned FracW = 23;
    localparam int unsigned ExpW  = 8;
    localparam int unsigned MantW = FracW + 2;   // hidden bit plus carry

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ALIGN = 4'b0010,
        ST_NORM  = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    typedef struct packed {
        logic load;     // capture request operands
        logic align;    // align and add/subtract
        logic norm;     // one left-normalize step
    } cmd_t;

    typedef struct packed {
        logic bypass;   // result already final after align
        logic norm_done;
    } status_t;

endpackage

FILE: sv/fas_ctrl.sv
// fas_ctrl: controller state machine for the float32 add/sub block
// depends on fas_pkg
module fas_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  fas_pkg::status_t  status,
    output fas_pkg::cmd_t     cmd
);

    fas_pkg::state_t state_reg;
    fas_pkg::state_t state_next;

    logic load_ok;

    // output register is free or being emptied this cycle
    assign load_ok  = (state_reg == fas_pkg::ST_IDLE) ||
                      ((state_reg == fas_pkg::ST_DONE) && !out_stall);
    assign in_stall = !load_ok;
    assign out_valid = (state_reg == fas_pkg::ST_DONE);

    always_comb
    begin
        cmd.load  = load_ok && in_valid;
        cmd.align = (state_reg == fas_pkg::ST_ALIGN);
        cmd.norm  = (state_reg == fas_pkg::ST_NORM) && !status.norm_done;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fas_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = fas_pkg::ST_ALIGN;
            end
            fas_pkg::ST_ALIGN:
            begin
                if (status.bypass)
                    state_next = fas_pkg::ST_DONE;
                else
                    state_next = fas_pkg::ST_NORM;
            end
            fas_pkg::ST_NORM:
            begin
                if (status.norm_done)
                    state_next = fas_pkg::ST_DONE;
            end
            fas_pkg::ST_DONE:
            begin
                if (!out_stall)
                    state_next = in_valid ? fas_pkg::ST_ALIGN : fas_pkg::ST_IDLE;
            end
            default:
                state_next = fas_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fas_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: sv/fas_dp.sv
// fas_dp: datapath for the float32 add/sub block: operand capture, alignment,
// add/subtract and a one-bit-per-cycle normalize shifter; depends on fas_pkg
module fas_dp
(
    input  logic                            clk,
    input  fas_pkg::cmd_t                   cmd,
    input  logic                            op,
    input  logic [fas_pkg::WordW-1:0]       a,
    input  logic [fas_pkg::WordW-1:0]       b,
    output fas_pkg::status_t                status,
    output logic [fas_pkg::WordW-1:0]       result
);

    localparam int unsigned FW = fas_pkg::FracW;
    localparam int unsigned EW = fas_pkg::ExpW;
    localparam int unsigned MW = fas_pkg::MantW;

    logic [fas_pkg::WordW-1:0] a_reg, b_reg;
    logic [EW-1:0]             exp_reg;
    logic [MW-1:0]             mag_reg;
    logic                      sign_reg;
    logic                      byp_reg;
    logic [fas_pkg::WordW-1:0] byp_val_reg;

    // alignment and add/subtract, combinational from captured operands
    logic          sa, sb;
    logic [EW-1:0] ea, eb, e_big;
    logic [FW:0]   ma, mb, m_big, m_small, m_sh;
    logic [EW-1:0] diff;
    logic          lost;
    logic [MW-1:0] sum;
    logic          s_out;
    logic          zero_a, zero_b, cancel;
    logic [EW-1:0] e_out;
    logic [MW-1:0] m_out;

    always_comb
    begin
        sa = a_reg[fas_pkg::WordW-1];
        sb = b_reg[fas_pkg::WordW-1];
        ea = a_reg[FW +: EW];
        eb = b_reg[FW +: EW];
        ma = {1'b1, a_reg[FW-1:0]};
        mb = {1'b1, b_reg[FW-1:0]};
        zero_a = (a_reg[fas_pkg::WordW-2:0] == '0);
        zero_b = (b_reg[fas_pkg::WordW-2:0] == '0);
        if (ea >= eb)
        begin
            e_big = ea; m_big = ma; m_small = mb; diff = ea - eb;
        end
        else
        begin
            e_big = eb; m_big = mb; m_small = ma; diff = eb - ea;
        end
        // shifts beyond the mantissa width clear it; bit is lost either way
        if (diff > EW'(FW))
        begin
            m_sh = '0;
            lost = 1'b1;
        end
        else
        begin
            m_sh = m_small >> diff;
            lost = ((m_small & ((FW+1)'(1) << diff) - (FW+1)'(1)) != '0);
        end
        cancel = 1'b0;
        e_out  = e_big;
        if (sa == sb)
        begin
            s_out = sa;
            sum = {1'b0, m_big} + {1'b0, m_sh};
            m_out = sum;
            if (sum[MW-1])
            begin
                m_out = sum >> 1;
                e_out = e_big + EW'(1);
            end
        end
        else
        begin
            // aligned operand is ma when eb > ea, so recover side for sign
            if (ea >= eb)
            begin
                if (ma >= m_sh) begin s_out = sa; sum = {1'b0, ma - m_sh}; end
                else            begin s_out = sb; sum = {1'b0, m_sh - ma}; end
            end
            else
            begin
                if (m_sh >= mb) begin s_out = sa; sum = {1'b0, m_sh - mb}; end
                else            begin s_out = sb; sum = {1'b0, mb - m_sh}; end
            end
            m_out = sum;
            cancel = (sum == '0) && !(lost && (diff != '0));
        end
    end

    // bypass must be known during the align cycle itself
    assign status.bypass    = zero_a || zero_b || cancel;
    assign status.norm_done = mag_reg[FW] || (exp_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg <= a;
            b_reg <= {b[fas_pkg::WordW-1] ^ op, b[fas_pkg::WordW-2:0]};
        end
        if (cmd.align)
        begin
            exp_reg  <= e_out;
            mag_reg  <= m_out;
            sign_reg <= s_out;
            byp_reg  <= zero_a || zero_b || cancel;
            if (zero_a)
                byp_val_reg <= b_reg;
            else if (zero_b)
                byp_val_reg <= a_reg;
            else
                byp_val_reg <= '0;
        end
        else if (cmd.norm)
        begin
            mag_reg <= mag_reg << 1;
            exp_reg <= exp_reg - EW'(1);
        end
    end

    // bypass is decided in the align cycle; controller skips norm on bypass
    always_comb
    begin
        if (byp_reg)
            result = byp_val_reg;
        else
            result = {sign_reg, exp_reg, mag_reg[FW-1:0]};
    end

endmodule

FILE: sv/float32_add_sub_truncating.sv
// float32_add_sub_truncating: truncating binary32 add/subtract, top level
// sequence: align, then done when an operand is zero or the difference cancels
// exactly; otherwise align, normalize until hidden bit or exponent zero, done
// throughput: one request at a time; the normalize shifter moves one bit a cycle
// a new request is taken the cycle the previous result is taken
// reset: rst_n asynchronous active low returns the controller to idle
// depends on fas_pkg, fas_ctrl, fas_dp
module float32_add_sub_truncating
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic [fas_pkg::WordW-1:0]     a,
    input  logic [fas_pkg::WordW-1:0]     b,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fas_pkg::WordW-1:0]     result
);

    fas_pkg::cmd_t    cmd;
    fas_pkg::status_t status;
    fas_pkg::status_t status_g;

    // bypass is combinational from the captured operands during align
    assign status_g.bypass    = status.bypass;
    assign status_g.norm_done = status.norm_done;

    fas_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status_g),
        .cmd       (cmd)
    );

    fas_dp u_dp
    (
        .clk    (clk),
        .cmd    (cmd),
        .op     (op),
        .a      (a),
        .b      (b),
        .status (status),
        .result (result)
    );

endmodule

FILE: sv/fas_checker.sv
// fas_checker: port-level assertions for float32_add_sub_truncating
// bound to the top level below; depends on nothing else
module fas_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] result
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result))
        else $error("result changed while stalled");

    // result never shows in the cycle right after a request
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid)
        else $error("result too early");

    // a waiting result blocks new requests
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("request taken over a held result");

    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("valid during reset");

endmodule

bind float32_add_sub_truncating fas_checker u_fas_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
);
